// File: rtl/spts_pkg.sv
package spts_pkg;

    // store geometry
    localparam int MAX_ELEMENTS = 256;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int DATA_W       = 32;
    // exact pair sum needs one bit more, target minus element one more again
    localparam int SUM_W        = DATA_W + 2;

    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [SUM_W-1:0]  t_sum;

    // query launch towards the search sequencer
    typedef struct packed {
        logic  start;
        logic  triplet;
        t_cnt  count;
        t_data target;
    } t_walk_req;

    // search sequencer status back to the top level
    typedef struct packed {
        logic busy;
        logic done;
        logic found;
    } t_walk_rsp;

endpackage

// File: rtl/sorted_pair_triplet_sum_search.sv
// Append requests produce no result.
// Pair query: one pointer step per cycle on the two read ports.
// Triplet query: an extra load state before the walk for each fixed element.
// Requests are taken one at a time; a result waits in the output register.
// Synchronous active-low reset clears count, overflow flag, mode and handshakes;
// store contents are not cleared and are only read below the element count.
module sorted_pair_triplet_sum_search (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_req_type,
    input  logic                 i_start_new,
    input  logic signed [31:0]   i_value,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_found,
    output logic                 o_dropped
);

    logic                r_triplet_mode;
    spts_pkg::t_cnt      r_count, n_count;
    logic                r_ovf, n_ovf;
    logic                r_o_valid;
    logic                r_o_found;
    logic                r_o_dropped;

    logic                accept;
    logic                out_free;
    logic                we;
    spts_pkg::t_addr     waddr;
    spts_pkg::t_addr     addr_a, addr_b;
    spts_pkg::t_data     rd_a, rd_b;
    spts_pkg::t_walk_req walk_req;
    spts_pkg::t_walk_rsp walk_rsp;

    // handshakes
    assign o_ready  = !walk_rsp.busy;
    assign accept   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;

    // append path: write at the fill count (restart at zero on start_new), drop and flag when full
    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        we      = 1'b0;
        waddr   = r_count[spts_pkg::ADDR_W-1:0];
        if (accept && !i_req_type) begin
            if (i_start_new) begin
                we      = 1'b1;
                waddr   = '0;
                n_count = spts_pkg::CNT_W'(1);
                n_ovf   = 1'b0;
            end else if (r_count < spts_pkg::CNT_W'(spts_pkg::MAX_ELEMENTS)) begin
                we      = 1'b1;
                n_count = r_count + spts_pkg::CNT_W'(1);
            end else begin
                n_ovf   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_ovf          <= 1'b0;
            r_triplet_mode <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
            if (i_cfg_we) begin
                r_triplet_mode <= i_cfg_data;
            end
        end
    end

    // query launch
    assign walk_req.start   = accept && i_req_type;
    assign walk_req.triplet = r_triplet_mode;
    assign walk_req.count   = r_count;
    assign walk_req.target  = i_value;

    spts_ram u_ram (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (i_value),
        .i_addr_a (addr_a),
        .i_addr_b (addr_b),
        .o_rd_a   (rd_a),
        .o_rd_b   (rd_b)
    );

    spts_walk u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (walk_req),
        .i_out_free (out_free),
        .i_rd_a     (rd_a),
        .i_rd_b     (rd_b),
        .o_addr_a   (addr_a),
        .o_addr_b   (addr_b),
        .o_rsp      (walk_rsp)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (walk_rsp.done) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (walk_rsp.done) begin
            r_o_found   <= walk_rsp.found;
            r_o_dropped <= r_ovf;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_found   = r_o_found;
    assign o_dropped = r_o_dropped;

    // fill count never passes capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spts_pkg::CNT_W'(spts_pkg::MAX_ELEMENTS))
        else $error("element count beyond capacity");

    // a finished search never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_rsp.done |-> (!r_o_valid || i_ready))
        else $error("result overwritten");

    // append to a full store sets the overflow flag
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_req_type && !i_start_new
         && r_count == spts_pkg::CNT_W'(spts_pkg::MAX_ELEMENTS)) |=> r_ovf)
        else $error("dropped append not flagged");

    // a taken query starts the search, so no request is taken while it runs
    a_idle_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_req.start |=> walk_rsp.busy)
        else $error("query did not start the search");

endmodule

// File: rtl/spts_ram.sv
module spts_ram (
    input  logic           i_clk,
    input  logic           i_we,
    input  spts_pkg::t_addr i_waddr,
    input  spts_pkg::t_data i_wdata,
    input  spts_pkg::t_addr i_addr_a,
    input  spts_pkg::t_addr i_addr_b,
    output spts_pkg::t_data o_rd_a,
    output spts_pkg::t_data o_rd_b
);

    // element store: one write port, two registered read ports
    spts_pkg::t_data r_mem [spts_pkg::MAX_ELEMENTS];
    spts_pkg::t_data r_rd_a;
    spts_pkg::t_data r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_addr_a];
        r_rd_b <= r_mem[i_addr_b];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

// File: rtl/spts_walk.sv
module spts_walk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spts_pkg::t_walk_req i_req,
    input  logic                i_out_free,
    input  spts_pkg::t_data     i_rd_a,
    input  spts_pkg::t_data     i_rd_b,
    output spts_pkg::t_addr     o_addr_a,
    output spts_pkg::t_addr     o_addr_b,
    output spts_pkg::t_walk_rsp o_rsp
);

    localparam spts_pkg::t_cnt PAIR_MIN = spts_pkg::CNT_W'(2);
    localparam spts_pkg::t_cnt TRIP_MIN = spts_pkg::CNT_W'(3);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_WALK = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic            r_trip, n_trip;
    logic            r_found, n_found;
    spts_pkg::t_cnt  r_n, n_n;
    spts_pkg::t_addr r_i, n_i;
    spts_pkg::t_cnt  r_lo, n_lo;
    spts_pkg::t_cnt  r_hi, n_hi;
    spts_pkg::t_data r_target, n_target;
    spts_pkg::t_sum  r_t, n_t;

    spts_pkg::t_sum  sum;
    spts_pkg::t_cnt  i_next;

    // exact sum of the two pointed elements
    assign sum = spts_pkg::SUM_W'(i_rd_a) + spts_pkg::SUM_W'(i_rd_b);
    assign i_next = spts_pkg::CNT_W'(r_i) + spts_pkg::CNT_W'(1);

    // sequencer: read data arrives in the cycle after the next pointers are issued
    always_comb begin
        n_state  = r_state;
        n_trip   = r_trip;
        n_found  = r_found;
        n_n      = r_n;
        n_i      = r_i;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_target = r_target;
        n_t      = r_t;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_trip   = i_req.triplet;
                    n_n      = i_req.count;
                    n_target = i_req.target;
                    n_found  = 1'b0;
                    n_i      = '0;
                    n_lo     = '0;
                    n_hi     = i_req.count - spts_pkg::CNT_W'(1);
                    n_t      = spts_pkg::SUM_W'(i_req.target);
                    if (!i_req.triplet) begin
                        n_state = (i_req.count < PAIR_MIN) ? S_FIN : S_WALK;
                    end else begin
                        n_state = (i_req.count < TRIP_MIN) ? S_FIN : S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                // fixed element is on port a; walk the elements after it
                n_t     = spts_pkg::SUM_W'(r_target) - spts_pkg::SUM_W'(i_rd_a);
                n_lo    = i_next;
                n_hi    = r_n - spts_pkg::CNT_W'(1);
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_lo < r_hi) begin
                    if (sum == r_t) begin
                        n_found = 1'b1;
                        n_state = S_FIN;
                    end else if (sum > r_t) begin
                        n_hi = r_hi - spts_pkg::CNT_W'(1);
                    end else begin
                        n_lo = r_lo + spts_pkg::CNT_W'(1);
                    end
                end else if (r_trip && (i_next < r_n)) begin
                    n_i     = i_next[spts_pkg::ADDR_W-1:0];
                    n_state = S_LOAD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_trip   <= n_trip;
        r_found  <= n_found;
        r_n      <= n_n;
        r_i      <= n_i;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_target <= n_target;
        r_t      <= n_t;
    end

    // read addresses follow the next pointers; out-of-range pointers are never used
    assign o_addr_a = (n_state == S_LOAD) ? n_i : n_lo[spts_pkg::ADDR_W-1:0];
    assign o_addr_b = n_hi[spts_pkg::ADDR_W-1:0];

    assign o_rsp.busy  = (r_state != S_IDLE);
    assign o_rsp.done  = (r_state == S_FIN) && i_out_free;
    assign o_rsp.found = r_found;

endmodule
